// ===== design/lfmc_pkg.sv =====
package lfmc_pkg;

  // counter width of the shared ramp/stop timer
  localparam int unsigned TimerBits = 16;
  localparam int unsigned PeriodBits = 16;
  localparam int unsigned CmpBits = (TimerBits > PeriodBits) ? TimerBits : PeriodBits;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLineWhite  = 2'd0,
    CfgRampPeriod = 2'd1,
    CfgStopPeriod = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    GoalRamp = 1'b0,
    GoalStop = 1'b1
  } goal_e;

  // sensor patterns (bits 1 to 5 of the port)
  localparam logic [7:0] PatAll      = 8'h3E;
  localparam logic [7:0] PatHardL    = 8'h30;
  localparam logic [7:0] PatHardR    = 8'h06;
  localparam logic [7:0] PatMidL     = 8'h32;
  localparam logic [7:0] PatMidR     = 8'h26;
  localparam logic [7:0] PatSoftL    = 8'h3A;
  localparam logic [7:0] PatSoftR    = 8'h2E;
  localparam logic [7:0] PatStraight = 8'h36;

  localparam logic [PeriodBits-1:0] ResetRampPeriod = 16'd5200;
  localparam logic [PeriodBits-1:0] ResetStopPeriod = 16'd31250;

  localparam logic [7:0] ResetDuty      = 8'd120;
  localparam logic [7:0] ResetDirection = 8'd6;
  localparam logic [7:0] StopDirection  = 8'd0;
  localparam logic [1:0] MaxLevel       = 2'd3;

  typedef struct packed {
    logic                  line_is_white;
    logic [PeriodBits-1:0] ramp_period;
    logic [PeriodBits-1:0] stop_period;
  } cfg_t;

  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic       pwm_on;
    logic [7:0] direction_bits;
    logic [1:0] speed_level;
  } res_t;

  // straight-line duty by speed level
  function automatic logic [7:0] speed_duty(input logic [1:0] lvl);
    logic [7:0] d;
    case (lvl)
      2'd0:    d = 8'd170;
      2'd1:    d = 8'd170;
      2'd2:    d = 8'd180;
      2'd3:    d = 8'd180;
      default: d = 8'd170;
    endcase
    return d;
  endfunction

endpackage

// ===== design/lfmc_if.sv =====
interface lfmc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] sensor_port;

  modport source (output valid, output mode, output sensor_port, input ready);
  modport sink (input valid, input mode, input sensor_port, output ready);
endinterface

interface lfmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_a;
  logic [7:0] duty_b;
  logic       pwm_on;
  logic [7:0] direction_bits;
  logic [1:0] speed_level;

  modport source (output valid, output duty_a, output duty_b, output pwm_on,
                  output direction_bits, output speed_level, input ready);
  modport sink (input valid, input duty_a, input duty_b, input pwm_on,
                input direction_bits, input speed_level, output ready);
endinterface

// ===== design/lfmc_cfg_regs.sv =====
module lfmc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfmc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lfmc_pkg::CfgDataBits-1:0] cfg_data_i,
  output lfmc_pkg::cfg_t                   cfg_o
);
  import lfmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLineWhite:  cfg_d.line_is_white = cfg_data_i[0];
        CfgRampPeriod: cfg_d.ramp_period   = cfg_data_i[PeriodBits-1:0];
        CfgStopPeriod: cfg_d.stop_period   = cfg_data_i[PeriodBits-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_is_white <= 1'b0;
      cfg_q.ramp_period   <= ResetRampPeriod;
      cfg_q.stop_period   <= ResetStopPeriod;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lfmc_ctrl.sv =====
module lfmc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           mode_i,
  input  logic [7:0]     port_i,
  input  lfmc_pkg::cfg_t cfg_i,
  output lfmc_pkg::res_t res_o
);
  import lfmc_pkg::*;

  logic [7:0]           duty_a_q, duty_a_d;
  logic [7:0]           duty_b_q, duty_b_d;
  logic                 pwm_q, pwm_d;
  logic [7:0]           dir_q, dir_d;
  logic [1:0]           level_q, level_d;
  logic                 run_q, run_d;
  logic [TimerBits-1:0] cnt_q, cnt_d;
  goal_e                goal_q, goal_d;

  logic [7:0]           pat;
  logic [TimerBits-1:0] cnt_inc;
  logic [PeriodBits-1:0] period;
  logic                 period_done;
  logic [1:0]           level_up;

  assign pat         = port_i ^ (cfg_i.line_is_white ? PatAll : 8'h00);
  assign cnt_inc     = cnt_q + TimerBits'(1);
  assign period      = (goal_q == GoalStop) ? cfg_i.stop_period : cfg_i.ramp_period;
  assign period_done = CmpBits'(cnt_inc) >= CmpBits'(period);
  assign level_up    = level_q + 2'd1;

  always_comb begin
    duty_a_d = duty_a_q;
    duty_b_d = duty_b_q;
    pwm_d    = pwm_q;
    dir_d    = dir_q;
    level_d  = level_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    goal_d   = goal_q;
    if (!mode_i) begin
      // sensor change: any running timer stops; all-line and straight start a new one
      run_d = 1'b0;
      if (pat == PatAll) begin
        run_d  = 1'b1;
        goal_d = GoalStop;
        cnt_d  = '0;
      end else begin
        pwm_d = 1'b1;
        case (pat)
          PatHardL: begin
            duty_a_d = 8'd185;
            duty_b_d = 8'd0;
          end
          PatHardR: begin
            duty_a_d = 8'd0;
            duty_b_d = 8'd185;
          end
          PatMidL: begin
            duty_a_d = 8'd180;
            duty_b_d = 8'd120;
          end
          PatMidR: begin
            duty_a_d = 8'd120;
            duty_b_d = 8'd180;
          end
          PatSoftL: begin
            duty_a_d = 8'd170;
            duty_b_d = 8'd135;
          end
          PatSoftR: begin
            duty_a_d = 8'd135;
            duty_b_d = 8'd170;
          end
          PatStraight: begin
            level_d  = 2'd0;
            duty_a_d = speed_duty(2'd0);
            duty_b_d = speed_duty(2'd0);
            run_d    = 1'b1;
            goal_d   = GoalRamp;
            cnt_d    = '0;
          end
          default: begin
            pwm_d = 1'b1;
          end
        endcase
      end
    end else if (run_q) begin
      // timer tick
      if (!period_done) begin
        cnt_d = cnt_inc;
      end else begin
        cnt_d = '0;
        if (goal_q == GoalRamp) begin
          if (level_q != MaxLevel) begin
            level_d  = level_up;
            duty_a_d = speed_duty(level_up);
            duty_b_d = speed_duty(level_up);
          end
        end else begin
          dir_d = StopDirection;
          pwm_d = 1'b0;
          run_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_a_q <= ResetDuty;
      duty_b_q <= ResetDuty;
      pwm_q    <= 1'b1;
      dir_q    <= ResetDirection;
      level_q  <= 2'd0;
      run_q    <= 1'b0;
      cnt_q    <= '0;
      goal_q   <= GoalRamp;
    end else if (adv_i) begin
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      pwm_q    <= pwm_d;
      dir_q    <= dir_d;
      level_q  <= level_d;
      run_q    <= run_d;
      cnt_q    <= cnt_d;
      goal_q   <= goal_d;
    end
  end

  // result is the state after the update
  always_comb begin
    res_o.duty_a         = duty_a_d;
    res_o.duty_b         = duty_b_d;
    res_o.pwm_on         = pwm_d;
    res_o.direction_bits = dir_d;
    res_o.speed_level    = level_d;
  end

endmodule

// ===== design/line_follower_motor_control_core.sv =====
// line follower motor control core: each request is either a sensor port change (mode 0) or
// one prescaled timer tick (mode 1), and produces exactly one result carrying both pwm duties,
// the pwm enable, the motor direction byte and the current speed level, all taken after the
// update. a request is latched in an input register, the state update is one short step of
// logic, and the result sits in an output register; one request is taken every clock cycle
// while results are being drained. when the output is stalled the input register holds one
// more request before ready drops.
// configuration (line colour, ramp and stop periods) is written through the plain write port
// and must only change while no request is in flight; a write is seen from the next cycle.
module line_follower_motor_control_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lfmc_in_if.sink                          in_if,
  lfmc_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [lfmc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lfmc_pkg::CfgDataBits-1:0] cfg_data_i
);
  import lfmc_pkg::*;

  cfg_t       cfg;
  res_t       res;

  // input register
  logic       in_vld_q;
  logic       in_mode_q;
  logic [7:0] in_port_q;

  // result register
  logic       out_vld_q;
  res_t       out_q;

  logic       adv;
  logic       in_take;

  // the request in the input register moves on once the result slot is free or draining
  assign adv     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_take = in_if.valid && in_if.ready;

  assign in_if.ready = !in_vld_q || adv;

  lfmc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .mode_i (in_mode_q),
    .port_i (in_port_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= in_if.mode;
      in_port_q <= in_if.sensor_port;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.duty_a         = out_q.duty_a;
  assign out_if.duty_b         = out_q.duty_b;
  assign out_if.pwm_on         = out_q.pwm_on;
  assign out_if.direction_bits = out_q.direction_bits;
  assign out_if.speed_level    = out_q.speed_level;

endmodule

// ===== sim/lfmc_motor_check.sv =====
`timescale 1ns / 1ps
// watches both channels and the register port, predicts each result and compares
module lfmc_motor_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lfmc_in_if                               in_if,
  lfmc_out_if                              out_if,
  input  logic                             cfg_we_i,
  input  logic [lfmc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lfmc_pkg::CfgDataBits-1:0] cfg_data_i,
  output int unsigned                      errors_o,
  output int unsigned                      pending_o,
  output int unsigned                      compared_o
);
  import lfmc_pkg::*;

  typedef struct packed {
    logic [7:0]           duty_a;
    logic [7:0]           duty_b;
    logic                 pwm_on;
    logic [7:0]           direction;
    logic [1:0]           level;
    logic                 running;
    logic [TimerBits-1:0] ticks;
    goal_e                goal;
  } motor_state_t;

  localparam logic [7:0] StraightDuty [4] = '{8'd170, 8'd170, 8'd180, 8'd180};

  motor_state_t motor;
  cfg_t         regs;
  res_t         expected_q [$];
  int unsigned  err_count;
  int unsigned  cmp_count;

  function automatic motor_state_t advance(input motor_state_t s, input cfg_t c,
                                           input logic mode, input logic [7:0] port);
    motor_state_t          n;
    logic [7:0]            pat;
    logic [PeriodBits-1:0] span;
    n = s;
    if (mode) begin
      if (n.running) begin
        span    = (n.goal == GoalStop) ? c.stop_period : c.ramp_period;
        n.ticks = n.ticks + 1'b1;
        if (n.ticks >= span) begin
          n.ticks = '0;
          if (n.goal == GoalRamp) begin
            // at the top level the period still completes, timer keeps going
            if (n.level < MaxLevel) begin
              n.level  = n.level + 1'b1;
              n.duty_a = StraightDuty[n.level];
              n.duty_b = StraightDuty[n.level];
            end
          end else begin
            n.direction = StopDirection;
            n.pwm_on    = 1'b0;
            n.running   = 1'b0;
          end
        end
      end
    end else begin
      pat       = port ^ (c.line_is_white ? PatAll : 8'h00);
      n.running = 1'b0;
      if (pat == PatAll) begin
        n.running = 1'b1;
        n.goal    = GoalStop;
        n.ticks   = '0;
      end else begin
        n.pwm_on = 1'b1;
        case (pat)
          PatHardL: {n.duty_a, n.duty_b} = {8'd185, 8'd0};
          PatHardR: {n.duty_a, n.duty_b} = {8'd0, 8'd185};
          PatMidL:  {n.duty_a, n.duty_b} = {8'd180, 8'd120};
          PatMidR:  {n.duty_a, n.duty_b} = {8'd120, 8'd180};
          PatSoftL: {n.duty_a, n.duty_b} = {8'd170, 8'd135};
          PatSoftR: {n.duty_a, n.duty_b} = {8'd135, 8'd170};
          PatStraight: begin
            n.level   = '0;
            n.duty_a  = StraightDuty[0];
            n.duty_b  = StraightDuty[0];
            n.running = 1'b1;
            n.goal    = GoalRamp;
            n.ticks   = '0;
          end
          default: ;
        endcase
      end
    end
    return n;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      motor      = '{duty_a: ResetDuty, duty_b: ResetDuty, pwm_on: 1'b1,
                     direction: ResetDirection, level: '0, running: 1'b0,
                     ticks: '0, goal: GoalRamp};
      regs       = '{line_is_white: 1'b0, ramp_period: ResetRampPeriod,
                     stop_period: ResetStopPeriod};
      expected_q.delete();
      err_count  = 0;
      cmp_count  = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      compared_o <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        motor = advance(motor, regs, in_if.mode, in_if.sensor_port);
        expected_q.push_back('{duty_a: motor.duty_a, duty_b: motor.duty_b,
                               pwm_on: motor.pwm_on, direction_bits: motor.direction,
                               speed_level: motor.level});
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t result with nothing expected: %0d/%0d pwm %0d dir %0d level %0d",
                     $realtime, out_if.duty_a, out_if.duty_b, out_if.pwm_on,
                     out_if.direction_bits, out_if.speed_level);
        end else begin
          want = expected_q.pop_front();
          cmp_count++;
          check_field("duty_a", want.duty_a, out_if.duty_a);
          check_field("duty_b", want.duty_b, out_if.duty_b);
          check_field("pwm_on", want.pwm_on, out_if.pwm_on);
          check_field("direction_bits", want.direction_bits, out_if.direction_bits);
          check_field("speed_level", want.speed_level, out_if.speed_level);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLineWhite:  regs.line_is_white = cfg_data_i[0];
          CfgRampPeriod: regs.ramp_period = cfg_data_i[PeriodBits-1:0];
          CfgStopPeriod: regs.stop_period = cfg_data_i[PeriodBits-1:0];
          default: ;
        endcase
      end
      errors_o   <= err_count;
      pending_o  <= expected_q.size();
      compared_o <= cmp_count;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the motor control core; prediction lives in lfmc_motor_check
module tb_top;
  import lfmc_pkg::*;

  // far above the slowest correct run
  localparam int unsigned CycleLimit       = 400000;
  // extra settling once every expected result has been seen
  localparam int unsigned SettleCycles     = 8;
  localparam int unsigned RandomPerSetting = 170;

  // the six steering patterns, used as the content of well-formed episodes
  localparam logic [7:0] TurnPat [6] = '{PatHardL, PatHardR, PatMidL, PatMidR,
                                         PatSoftL, PatSoftR};

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;

  int unsigned errors;
  int unsigned pending;
  int unsigned compared;

  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned settings_count = 0;
  int unsigned req_idle_pct = 0;
  int unsigned res_idle_pct = 0;

  // local copy of the register values, used for the line colour and to size tick bursts
  cfg_t regs_now;

  lfmc_in_if  req_ch ();
  lfmc_out_if res_ch ();

  line_follower_motor_control_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (req_ch),
    .out_if     (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  lfmc_motor_check u_motor_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (req_ch),
    .out_if     (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .compared_o (compared)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("line_follower_motor_control_core regression: fail");
      $finish;
    end
  end

  // receiver back-pressure, one fresh draw every cycle
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= res_idle_pct);
  end

  // one request; valid stays high into the next request unless a gap is drawn,
  // so it never gets two assignments in the same step
  task automatic send_req(input logic mode, input logic [7:0] port);
    if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.sensor_port <= port;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // sensor change carrying a pattern as the block sees it after the line colour
  task automatic send_pattern(input logic [7:0] pat);
    send_req(1'b0, pat ^ (regs_now.line_is_white ? PatAll : 8'h00));
  endtask

  // timer ticks; the port byte is ignored on a tick but still randomised
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_req(1'b1, 8'($urandom));
  endtask

  // stop sending and wait until every expected result has been seen
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgLineWhite:  regs_now.line_is_white = data[0];
      CfgRampPeriod: regs_now.ramp_period = data[PeriodBits-1:0];
      CfgStopPeriod: regs_now.stop_period = data[PeriodBits-1:0];
      default: ;
    endcase
  endtask

  // registers only change with nothing in flight
  task automatic apply_setting(input logic white, input logic [PeriodBits-1:0] ramp,
                               input logic [PeriodBits-1:0] stop);
    drain();
    write_reg(CfgLineWhite, CfgDataBits'(white));
    write_reg(CfgRampPeriod, ramp);
    write_reg(CfgStopPeriod, stop);
    settings_count++;
  endtask

  // mostly a timer start followed by a random burst of up to 60 ticks,
  // otherwise a turn, a random port byte or stray ticks
  task automatic run_episode();
    int unsigned pick;
    int unsigned lim;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_pattern(PatStraight);
      lim = 3 * regs_now.ramp_period + 4;
      if (lim > 60) lim = 60;
      send_ticks($urandom_range(lim));
    end else if (pick < 55) begin
      send_pattern(PatAll);
      lim = regs_now.stop_period + 3;
      if (lim > 60) lim = 60;
      send_ticks($urandom_range(lim));
    end else if (pick < 75) begin
      send_pattern(TurnPat[$urandom_range(5)]);
      send_ticks($urandom_range(3));
    end else if (pick < 90) begin
      send_req(1'b0, 8'($urandom));
    end else begin
      send_ticks($urandom_range(1, 3));
    end
  endtask

  initial begin
    int unsigned first;
    // every input known from time zero
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CfgLineWhite;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = 1'b0;
    req_ch.sensor_port = '0;
    res_ch.ready       = 1'b0;
    regs_now           = '{line_is_white: 1'b0, ramp_period: ResetRampPeriod,
                           stop_period: ResetStopPeriod};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, sender idles lightly and receiver heavily
    req_idle_pct = 8;
    res_idle_pct = 59;

    // reset registers: tick with no timer, every steering pattern, unknown bytes
    send_ticks(1);
    foreach (TurnPat[i]) send_pattern(TurnPat[i]);
    send_req(1'b0, 8'h00);
    send_req(1'b0, 8'hFF);
    send_req(1'b0, 8'h3F);     // all-line with bit 0 set is not all-line
    send_req(1'b0, 8'hF6);     // straight with the top bits set is unknown
    send_pattern(PatStraight);
    send_ticks(1);
    send_pattern(PatAll);

    // shortest periods on a white line: ramp right to the top level and beyond,
    // then let the stop timer fire
    apply_setting(1'b1, 16'd1, 16'd1);
    send_pattern(PatStraight);
    send_ticks(4);
    send_pattern(PatAll);
    send_ticks(1);

    // period lowered below the running count, and a stop period of zero
    apply_setting(1'b0, 16'd40, 16'd0);
    send_pattern(PatStraight);
    send_ticks(3);
    apply_setting(1'b0, 16'd2, 16'd0);
    send_ticks(1);
    send_pattern(PatAll);
    send_ticks(1);

    // random part over six register settings and three idling mixes
    for (int s = 0; s < 6; s++) begin
      req_idle_pct = (s < 2) ? 8 : (s < 4) ? 59 : 0;
      res_idle_pct = (s < 2) ? 59 : (s < 4) ? 8 : 0;
      case (s)
        0: apply_setting(1'b0, 16'd1, 16'd1);
        1: apply_setting(1'b1, 16'($urandom_range(2, 12)), 16'($urandom_range(2, 12)));
        2: apply_setting(1'b0, 16'hFFFF, 16'hFFFF);
        3: apply_setting(1'b1, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)));
        4: apply_setting(1'b0, 16'($urandom_range(1, 8)), 16'($urandom_range(10, 40)));
        default: apply_setting(1'b1, 16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
      endcase
      first = items_sent;
      while (items_sent - first < RandomPerSetting) run_episode();
    end

    drain();
    $display("summary: %0d requests (sensor changes and ticks) over %0d register settings",
             items_sent, settings_count);
    $display("summary: %0d results compared, %0d mismatches, %0d still outstanding",
             compared, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("line_follower_motor_control_core regression: pass");
    end else begin
      $display("line_follower_motor_control_core regression: fail");
    end
    $finish;
  end

endmodule
